/* design/assert_macros.svh */
// Assertion macros used by the converter top level.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/bda_pkg.sv */
// Package for the binary to decimal ASCII converter.
// Holds constants, payload structs, cell control struct and the state enum.
package bda_pkg;

    localparam int NUM_DIGITS = 39;
    localparam int VALUE_BITS = 128;
    localparam int HALF_BITS  = 64;
    localparam int DEC_BASE   = 10;
    localparam int ASCII_ZERO = 48;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = 7;
    localparam int DIG_CNT_W  = 6;
    // Smallest digit whose doubling reaches the base.
    localparam int HALF_BASE  = DEC_BASE / 2;

    typedef struct packed {
        logic [HALF_BITS-1:0] value_high;
        logic [HALF_BITS-1:0] value_low;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } t_out;

    typedef struct packed {
        logic clear;
        logic dbl;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

endpackage

/* design/bda_cell.sv */
// One decimal digit cell of the conversion chain.
// Depends on bda_pkg for widths and the cell control struct.
module bda_cell (
    input  logic                        i_clk,
    input  bda_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_carry,
    input  logic [bda_pkg::DIGIT_W-1:0] i_shift_digit,
    output logic [bda_pkg::DIGIT_W-1:0] o_digit,
    output logic                        o_carry
);

    logic [bda_pkg::DIGIT_W-1:0] r_digit;
    logic [bda_pkg::DIGIT_W-1:0] n_digit;
    logic [bda_pkg::DIGIT_W:0]   w_dbl;

    // Carry out depends on the held digit alone: 2d + c reaches ten iff d >= 5.
    assign o_carry = (r_digit >= bda_pkg::DIGIT_W'(bda_pkg::HALF_BASE));
    assign w_dbl   = {r_digit, i_carry};

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.dbl) begin
            if (o_carry) begin
                n_digit = bda_pkg::DIGIT_W'(w_dbl - (bda_pkg::DIGIT_W + 1)'(bda_pkg::DEC_BASE));
            end else begin
                n_digit = w_dbl[bda_pkg::DIGIT_W-1:0];
            end
        end else if (i_ctl.shift) begin
            n_digit = i_shift_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

/* design/binary_to_decimal_ascii.sv */
// Binary to decimal ASCII converter, top level.
// Depends on bda_pkg, bda_cell and assert_macros.svh.
//
// Usage:
//   Raise i_start with a 128-bit value on i_data (two 64-bit halves) while
//   o_busy is low; that edge accepts the transaction. The block then holds
//   o_busy high until it has loaded its last character into the output register.
//   Characters leave on o_result, one per cycle while o_valid is high, most
//   significant digit first, leading zeros dropped. last_digit marks the
//   final character. A zero value gives a single '0'.
//   The receiver cannot stall: each character shows for exactly one cycle.
// Timing:
//   A row of 39 digit cells doubles and adds the next input bit, one bit per
//   cycle, through all 128 bits. The row then shifts toward the top cell,
//   one digit a cycle: leading zeros are dropped silently, then the first
//   nonzero digit is checked and the characters are emitted in turn.
//   The first character appears in the cycle after the first emit cycle.
//   The last character shows in the first cycle after busy drops, and a new
//   transaction can be taken in that same cycle; none is taken while busy.
// Reset:
//   Synchronous active-low i_rst_n returns the controller to idle and drops
//   o_valid; digit cells are cleared at the start of each transaction.
`include "assert_macros.svh"

module binary_to_decimal_ascii (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bda_pkg::t_in  i_data,
    output logic          o_busy,
    output logic          o_valid,
    output bda_pkg::t_out o_result
);

    bda_pkg::t_state                 r_state;
    bda_pkg::t_state                 n_state;
    logic [bda_pkg::VALUE_BITS-1:0]  r_value;
    logic [bda_pkg::VALUE_BITS-1:0]  n_value;
    logic [bda_pkg::BIT_CNT_W-1:0]   r_bit_cnt;
    logic [bda_pkg::BIT_CNT_W-1:0]   n_bit_cnt;
    logic [bda_pkg::DIG_CNT_W-1:0]   r_dig_cnt;
    logic [bda_pkg::DIG_CNT_W-1:0]   n_dig_cnt;
    logic                            r_valid;
    logic                            n_valid;
    bda_pkg::t_out                   r_result;
    bda_pkg::t_out                   n_result;
    bda_pkg::t_cell_ctl              w_ctl;
    logic                            w_accept;
    logic                            w_top_zero;
    logic                            w_last;
    logic                            w_char_ok;

    logic [bda_pkg::DIGIT_W-1:0] w_digit [bda_pkg::NUM_DIGITS];
    logic                        w_carry [bda_pkg::NUM_DIGITS];

    // Digit chain: cell 0 takes the input bit as carry and a zero on shifts.
    for (genvar k = 0; k < bda_pkg::NUM_DIGITS; k++) begin : g_cell
        if (k == 0) begin : g_first
            bda_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_carry      (r_value[bda_pkg::VALUE_BITS-1]),
                .i_shift_digit('0),
                .o_digit      (w_digit[k]),
                .o_carry      (w_carry[k])
            );
        end else begin : g_rest
            bda_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_carry      (w_carry[k-1]),
                .i_shift_digit(w_digit[k-1]),
                .o_digit      (w_digit[k]),
                .o_carry      (w_carry[k])
            );
        end
    end

    assign w_accept   = i_start && (r_state == bda_pkg::ST_IDLE);
    assign w_top_zero = (w_digit[bda_pkg::NUM_DIGITS-1] == '0);
    assign w_last     = (r_dig_cnt == bda_pkg::DIG_CNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bda_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = bda_pkg::ST_CONV;
                end
            end
            bda_pkg::ST_CONV: begin
                if (r_bit_cnt == '0) begin
                    n_state = bda_pkg::ST_SKIP;
                end
            end
            bda_pkg::ST_SKIP: begin
                if (!w_top_zero || w_last) begin
                    n_state = bda_pkg::ST_EMIT;
                end
            end
            bda_pkg::ST_EMIT: begin
                if (w_last) begin
                    n_state = bda_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bda_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and outputs.
    always_comb begin
        w_ctl     = '0;
        n_value   = r_value;
        n_bit_cnt = r_bit_cnt;
        n_dig_cnt = r_dig_cnt;
        n_valid   = 1'b0;
        n_result.digit_char = bda_pkg::CHAR_W'(bda_pkg::ASCII_ZERO)
                            + bda_pkg::CHAR_W'(w_digit[bda_pkg::NUM_DIGITS-1]);
        n_result.last_digit = w_last;
        case (r_state)
            bda_pkg::ST_IDLE: begin
                // Load the value and clear the chain on a new transaction.
                if (w_accept) begin
                    w_ctl.clear = 1'b1;
                    n_value     = i_data;
                    n_bit_cnt   = bda_pkg::BIT_CNT_W'(bda_pkg::VALUE_BITS - 1);
                end
            end
            bda_pkg::ST_CONV: begin
                // Double every digit and feed in the next bit, MSB first.
                w_ctl.dbl = 1'b1;
                n_value   = {r_value[bda_pkg::VALUE_BITS-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - 1'b1;
                n_dig_cnt = bda_pkg::DIG_CNT_W'(bda_pkg::NUM_DIGITS);
            end
            bda_pkg::ST_SKIP: begin
                // Drop leading zeros, keeping at least one digit.
                if (w_top_zero && !w_last) begin
                    w_ctl.shift = 1'b1;
                    n_dig_cnt   = r_dig_cnt - 1'b1;
                end
            end
            bda_pkg::ST_EMIT: begin
                // Present the top digit and advance the chain.
                w_ctl.shift = 1'b1;
                n_valid     = 1'b1;
                n_dig_cnt   = r_dig_cnt - 1'b1;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bda_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_bit_cnt <= n_bit_cnt;
        r_dig_cnt <= n_dig_cnt;
        r_result  <= n_result;
    end

    assign o_busy   = (r_state != bda_pkg::ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Character lies between '0' and '9'.
    assign w_char_ok =
        (o_result.digit_char >= bda_pkg::CHAR_W'(bda_pkg::ASCII_ZERO)) &&
        (o_result.digit_char <=
         bda_pkg::CHAR_W'(bda_pkg::ASCII_ZERO + bda_pkg::DEC_BASE - 1));

    `ASSERT_SAME(a_char_range, i_clk, i_rst_n, o_valid, w_char_ok)
    `ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_state == bda_pkg::ST_EMIT, o_valid)
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && o_result.last_digit, !o_valid)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, o_busy && (r_bit_cnt == bda_pkg::BIT_CNT_W'(bda_pkg::VALUE_BITS - 1)))

endmodule

/* tb/bda_decimal_checker.sv */
// Checker for the binary to decimal ASCII converter: predicts the digit characters of
// each accepted value and compares every character the block emits.
// Depends on bda_pkg.
module bda_decimal_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  bda_pkg::t_in  i_data,
    input  logic          i_valid,
    input  bda_pkg::t_out i_result,
    output int            o_fail_count,
    output int            o_pending
);

    bda_pkg::t_out decimal_chars_q[$];
    int            fail_count = 0;

    assign o_fail_count = fail_count;

    initial o_pending = 0;

    // Queue the decimal characters of one value, most significant first.
    task automatic queue_decimal_chars(input bda_pkg::t_in item);
        logic [bda_pkg::VALUE_BITS-1:0] rest;
        logic [bda_pkg::DIGIT_W-1:0]    digits [bda_pkg::NUM_DIGITS];
        bda_pkg::t_out                  one_char;
        int                             n;
        rest = {item.value_high, item.value_low};
        n = 0;
        do begin
            digits[n] = bda_pkg::DIGIT_W'(rest % bda_pkg::DEC_BASE);
            rest = rest / bda_pkg::DEC_BASE;
            n++;
        end while (rest != 0);
        for (int k = n - 1; k >= 0; k--) begin
            one_char.digit_char = bda_pkg::CHAR_W'(digits[k] + bda_pkg::ASCII_ZERO);
            one_char.last_digit = (k == 0);
            decimal_chars_q.push_back(one_char);
        end
    endtask

    always @(posedge i_clk) begin : watch
        bda_pkg::t_out want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (decimal_chars_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected character: expected none, got char %0d last %0b",
                             $time, i_result.digit_char, i_result.last_digit);
                end else begin
                    want = decimal_chars_q.pop_front();
                    if (i_result.digit_char !== want.digit_char ||
                        i_result.last_digit !== want.last_digit) begin
                        fail_count++;
                        $display("%0t: character mismatch: expected char %0d last %0b,",
                                 $time, want.digit_char, want.last_digit,
                                 " got char %0d last %0b",
                                 i_result.digit_char, i_result.last_digit);
                    end
                end
            end
            if (i_start && !i_busy)
                queue_decimal_chars(i_data);
        end
        o_pending <= decimal_chars_q.size();
    end

endmodule

/* tb/tb_binary_to_decimal_ascii.sv */
// Testbench top for binary_to_decimal_ascii: drives 128-bit values in bursts and
// gives the verdict. Depends on bda_pkg, the converter RTL and bda_decimal_checker.
module tb_binary_to_decimal_ascii;

    localparam int ITEM_TARGET   = 480;
    // About 500 transactions, stretched by idle gaps, must all finish well inside this
    // limit; it allows several times the expected run length.
    localparam int CYCLE_LIMIT   = 600000;
    // A bit more than one full conversion, to catch stray characters at the end.
    localparam int SETTLE_CYCLES = 200;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_start = 1'b0;
    bda_pkg::t_in  i_data  = '0;
    logic          o_busy;
    logic          o_valid;
    bda_pkg::t_out o_result;

    int    fail_count;
    int    pending;
    int    cycle_count = 0;

    always #10 i_clk = ~i_clk;

    binary_to_decimal_ascii dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_data   (i_data),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    bda_decimal_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_data       (i_data),
        .i_valid      (o_valid),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Abort a hung run: the block never finishing or never taking a transaction.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one value and hold start until the block takes the transaction.
    // Start is left high so that the next call keeps it up without a dip.
    task automatic send_value(input logic [bda_pkg::VALUE_BITS-1:0] value);
        i_start <= 1'b1;
        i_data  <= '{value_high: value[bda_pkg::VALUE_BITS-1:bda_pkg::HALF_BITS],
                     value_low:  value[bda_pkg::HALF_BITS-1:0]};
        do @(posedge i_clk); while (o_busy);
    endtask

    // Drop start for a number of cycles; scramble the idle data as noise.
    task automatic idle_for(input int cycles);
        i_start <= 1'b0;
        i_data  <= {$urandom, $urandom, $urandom, $urandom};
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop start and hold off until every expected character has come out.
    task automatic wait_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_busy);
    endtask

    // Pick a value with a spread of digit counts, not just 38- and 39-digit ones.
    function automatic logic [bda_pkg::VALUE_BITS-1:0] pick_value();
        logic [bda_pkg::VALUE_BITS-1:0] value;
        logic [bda_pkg::VALUE_BITS-1:0] mask;
        int                             shape;
        int                             exponent;
        shape = $urandom_range(0, 9);
        value = {$urandom, $urandom, $urandom, $urandom};
        if (shape < 4) begin
            // Full-width random: every bit toggles.
        end else if (shape < 7) begin
            // Random bit length, so leading-zero skipping sees every depth.
            mask  = {bda_pkg::VALUE_BITS{1'b1}} >> $urandom_range(0, bda_pkg::VALUE_BITS - 1);
            value = value & mask;
        end else if (shape < 9) begin
            // Near a power of ten, where the digit count steps.
            exponent = $urandom_range(0, bda_pkg::NUM_DIGITS - 1);
            value = 1;
            repeat (exponent) value = value * bda_pkg::DEC_BASE;
            value = value + $urandom_range(0, 2) - 1;
        end else begin
            value = $urandom_range(0, 999);
        end
        return value;
    endfunction

    initial begin : stimulus
        logic [bda_pkg::VALUE_BITS-1:0] pow10;
        int                             sent;
        int                             burst_len;
        int                             gap_len;

        // Hold reset at the start, then release it once for good.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, single digits, the half boundary, the extremes,
        // alternating bit patterns, and both sides of three digit-count steps.
        send_value('0);
        send_value(1);
        send_value(9);
        send_value(10);
        send_value({{bda_pkg::HALF_BITS{1'b0}}, {bda_pkg::HALF_BITS{1'b1}}});
        send_value({{(bda_pkg::HALF_BITS-1){1'b0}}, 1'b1, {bda_pkg::HALF_BITS{1'b0}}});
        send_value({bda_pkg::VALUE_BITS{1'b1}});
        send_value({1'b1, {(bda_pkg::VALUE_BITS-1){1'b0}}});
        send_value({32{4'hA}});
        send_value({32{4'h5}});
        pow10 = 1;
        for (int k = 1; k < bda_pkg::NUM_DIGITS; k++) begin
            pow10 = pow10 * bda_pkg::DEC_BASE;
            if (k == 1 || k == 19 || k == bda_pkg::NUM_DIGITS - 1) begin
                send_value(pow10 - 1);
                send_value(pow10);
            end
        end

        // Let the block go fully quiet once before the random part.
        wait_drained();

        // Random bursts: back-to-back values, then a gap that can land anywhere
        // in the block's conversion or emit phase, sometimes none at all.
        sent = 0;
        while (sent < ITEM_TARGET) begin
            burst_len = $urandom_range(1, 12);
            for (int i = 0; i < burst_len && sent < ITEM_TARGET; i++) begin
                send_value(pick_value());
                sent++;
            end
            case ($urandom_range(0, 7))
                0: wait_drained();
                1, 2: begin
                    // No gap: start stays high into the next burst.
                end
                3: begin
                    gap_len = $urandom_range(150, 220);
                    idle_for(gap_len);
                end
                default: begin
                    gap_len = $urandom_range(1, 40);
                    idle_for(gap_len);
                end
            endcase
        end

        // Drain, then watch a little longer for stray characters.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
